### sv/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, skipped while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### sv/tes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_pkg
// Shared constants, codes and control types of the timed event scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int NUM_EVENTS = 16;
    localparam int MAX_FIRES  = 64;

    localparam int IDX_W   = $clog2(NUM_EVENTS);
    localparam int CNT_W   = $clog2(NUM_EVENTS + 1);
    localparam int FIRE_AW = (MAX_FIRES > 1) ? $clog2(MAX_FIRES) : 1;
    localparam int NF_W    = $clog2(MAX_FIRES + 1);
    localparam int TIME_W  = 64;
    localparam int TICK_W  = 31;
    localparam int ID_W    = 4;
    localparam int ACT_W   = 4;
    localparam int DC_W    = 32;

    // action codes
    localparam logic [ACT_W-1:0] ACT_SCHED    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SETINT   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_SETPER   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ACTIVATE = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEACT    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DELAY    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_EARLY    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ADVANCE  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_QUERY    = 4'd8;
    localparam logic [ACT_W-1:0] ACT_INIT     = 4'd9;

    // result kinds
    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_ANSWER = 2'd2;

    // pending queue operation
    localparam logic [1:0] LM_NONE   = 2'd0;
    localparam logic [1:0] LM_ADD    = 2'd1;
    localparam logic [1:0] LM_RESORT = 2'd2;
    localparam logic [1:0] LM_REMOVE = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic run;
        logic fire;
        logic rem;
        logic ins;
        logic gset;
        logic fin;
        logic out;
    } cmd_t;

    typedef struct packed {
        logic       is_adv;
        logic       head_due;
        logic       fire_full;
        logic [1:0] lmode;
        logic       out_last;
    } stat_t;

    function automatic logic [TICK_W-1:0] sat31(input logic [TIME_W-1:0] v);
        return (v > TIME_W'({TICK_W{1'b1}})) ? {TICK_W{1'b1}} : v[TICK_W-1:0];
    endfunction

endpackage

### sv/tes_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_datapath
// Slot tables, time-ordered queue, fire record memory and result fields.
// ----------------------------------------------------------------------------
module tes_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tes_pkg::cmd_t               cmd,
    output tes_pkg::stat_t              stat,
    input  logic [3:0]                  action,
    input  logic [3:0]                  event_id,
    input  logic [30:0]                 ticks,
    input  logic [30:0]                 period_ticks,
    input  logic                        force_req,
    input  logic [30:0]                 backlog,
    output logic [1:0]                  kind,
    output logic [3:0]                  fired_id,
    output logic [30:0]                 run_gap,
    output logic [30:0]                 overdue,
    output logic [30:0]                 since_last,
    output logic [30:0]                 until_next,
    output logic [31:0]                 downcount,
    output logic                        queue_empty,
    output logic                        last
);
    import tes_pkg::*;

    // request registers
    logic [ACT_W-1:0]  act_reg,  act_next;
    logic [ID_W-1:0]   id_reg,   id_next;
    logic [TICK_W-1:0] tk_reg,   tk_next;
    logic [TICK_W-1:0] pin_reg,  pin_next;
    logic              frc_reg,  frc_next;
    logic [TIME_W-1:0] ts_reg,   ts_next;
    logic [TIME_W-1:0] nt_reg,   nt_next;
    logic [TIME_W-1:0] glob_reg, glob_next;
    logic [TIME_W-1:0] run_reg,  run_next;
    logic [TIME_W-1:0] rt_reg,   rt_next;

    // slot tables
    logic [TIME_W-1:0] nxt_reg [NUM_EVENTS];
    logic [TIME_W-1:0] nxt_next[NUM_EVENTS];
    logic [TIME_W-1:0] lst_reg [NUM_EVENTS];
    logic [TIME_W-1:0] lst_next[NUM_EVENTS];
    logic [TICK_W-1:0] int_reg [NUM_EVENTS];
    logic [TICK_W-1:0] int_next[NUM_EVENTS];
    logic [TICK_W-1:0] per_reg [NUM_EVENTS];
    logic [TICK_W-1:0] per_next[NUM_EVENTS];
    logic [NUM_EVENTS-1:0] on_reg, on_next;

    // ordered queue: slot ids and their next times
    logic [IDX_W-1:0]  ord_reg [NUM_EVENTS];
    logic [IDX_W-1:0]  ord_next[NUM_EVENTS];
    logic [TIME_W-1:0] pt_reg  [NUM_EVENTS];
    logic [TIME_W-1:0] pt_next [NUM_EVENTS];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  ins_reg, ins_next;
    logic [1:0]        lm_reg,  lm_next;
    logic [NF_W-1:0]   nf_reg,  nf_next;
    logic [NF_W-1:0]   ok_reg,  ok_next;
    logic              qry_reg, qry_next;
    logic [TICK_W-1:0] since_reg, since_next;
    logic [TICK_W-1:0] until_reg, until_next_v;
    logic [DC_W-1:0]   dc_reg,  dc_next;
    logic              emp_reg, emp_next;

    // fire record memory
    logic [IDX_W+TICK_W-1:0] fmem [MAX_FIRES];
    logic [IDX_W+TICK_W-1:0] rd_reg;
    logic                    we;
    logic [FIRE_AW-1:0]      waddr;
    logic [FIRE_AW-1:0]      raddr;
    logic [IDX_W+TICK_W-1:0] wdata;

    // combinational helpers
    logic [IDX_W-1:0]  sid, asel;
    logic              valid;
    logic [TIME_W-1:0] s_nxt, s_lst;
    logic [TICK_W-1:0] s_int, s_per;
    logic              s_on;
    logic [TIME_W-1:0] add_a, add_b, nv, tsd, dlst, h, hd;
    logic [TICK_W-1:0] tte_e, tte_f;
    logic [IDX_W-1:0]  p;
    logic              pf, fwd, bwd;
    logic [CNT_W-1:0]  c_le, c_lt, c_add;
    logic [NF_W-1:0]   nf_m1;

    assign sid   = IDX_W'(id_reg);
    assign valid = 32'(id_reg) < NUM_EVENTS;
    assign asel  = cmd.fire ? ord_reg[0] : sid;
    assign s_nxt = nxt_reg[asel];
    assign s_lst = lst_reg[asel];
    assign s_int = int_reg[asel];
    assign s_per = per_reg[asel];
    assign s_on  = on_reg[asel];
    assign h     = pt_reg[0];

    // shared adder for the slot commands
    assign add_a = (act_reg == ACT_DELAY) ? s_nxt : ts_reg;
    assign add_b = (act_reg == ACT_ACTIVATE || act_reg == ACT_EARLY)
                   ? TIME_W'(s_int) : TIME_W'(tk_reg);
    assign nv    = add_a + add_b;
    assign tsd   = ts_reg + TIME_W'(tk_reg);
    assign dlst  = ts_reg - s_lst;
    assign tte_e = sat31(dlst);
    assign hd    = h - s_lst;
    assign tte_f = (h >= s_lst) ? sat31(hd) : '0;
    assign nf_m1 = nf_reg - NF_W'(1);

    // position of the current slot and insertion counts
    always_comb
    begin
        p     = '0;
        pf    = 1'b0;
        fwd   = 1'b0;
        bwd   = 1'b0;
        c_le  = '0;
        c_lt  = '0;
        c_add = '0;
        for (int i = 0; i < NUM_EVENTS; i++)
        begin
            if (CNT_W'(i) < cnt_reg && ord_reg[i] == cur_reg)
            begin
                p  = IDX_W'(i);
                pf = 1'b1;
            end
        end
        for (int i = 0; i < NUM_EVENTS; i++)
        begin
            if (CNT_W'(i) < cnt_reg)
            begin
                if (rt_reg > pt_reg[i])
                    c_add = c_add + CNT_W'(1);
                if (!(pf && IDX_W'(i) == p))
                begin
                    if (pt_reg[i] <= rt_reg)
                        c_le = c_le + CNT_W'(1);
                    if (pt_reg[i] < rt_reg)
                        c_lt = c_lt + CNT_W'(1);
                end
                if (pf && IDX_W'(i) < p && pt_reg[i] > rt_reg)
                    fwd = 1'b1;
                if (pf && IDX_W'(i) > p && rt_reg > pt_reg[i])
                    bwd = 1'b1;
            end
        end
    end

    // next-state logic
    always_comb
    begin
        act_next     = act_reg;
        id_next      = id_reg;
        tk_next      = tk_reg;
        pin_next     = pin_reg;
        frc_next     = frc_reg;
        ts_next      = ts_reg;
        nt_next      = nt_reg;
        glob_next    = glob_reg;
        run_next     = run_reg;
        rt_next      = rt_reg;
        nxt_next     = nxt_reg;
        lst_next     = lst_reg;
        int_next     = int_reg;
        per_next     = per_reg;
        on_next      = on_reg;
        ord_next     = ord_reg;
        pt_next      = pt_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        ins_next     = ins_reg;
        lm_next      = lm_reg;
        nf_next      = nf_reg;
        ok_next      = ok_reg;
        qry_next     = qry_reg;
        since_next   = since_reg;
        until_next_v = until_reg;
        dc_next      = dc_reg;
        emp_next     = emp_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;

        // capture a request
        if (cmd.load)
        begin
            act_next = action;
            id_next  = event_id;
            tk_next  = ticks;
            pin_next = period_ticks;
            frc_next = force_req;
            ts_next  = glob_reg + TIME_W'(backlog);
            nt_next  = run_reg + TIME_W'(backlog);
            nf_next  = '0;
            qry_next = 1'b0;
            lm_next  = LM_NONE;
        end

        // slot command
        if (cmd.exec && valid)
        begin
            cur_next = sid;
            case (act_reg)
                ACT_SCHED, ACT_SETINT, ACT_SETPER:
                begin
                    if (act_reg == ACT_SETPER)
                        per_next[sid] = tk_reg;
                    if (act_reg != ACT_SCHED)
                        int_next[sid] = tk_reg;
                    nxt_next[sid] = tsd;
                    rt_next       = tsd;
                    if (!s_on)
                    begin
                        lst_next[sid] = ts_reg;
                        on_next[sid]  = 1'b1;
                        lm_next       = LM_ADD;
                    end
                    else
                        lm_next = LM_RESORT;
                end
                ACT_ACTIVATE:
                begin
                    if (!s_on)
                    begin
                        nxt_next[sid] = nv;
                        lst_next[sid] = ts_reg;
                        on_next[sid]  = 1'b1;
                        rt_next       = nv;
                        lm_next       = LM_ADD;
                    end
                end
                ACT_DEACT:
                begin
                    if (s_on)
                    begin
                        on_next[sid] = 1'b0;
                        lm_next      = LM_REMOVE;
                    end
                end
                ACT_DELAY:
                begin
                    if (s_on)
                    begin
                        nxt_next[sid] = nv;
                        rt_next       = nv;
                        lm_next       = LM_RESORT;
                    end
                end
                ACT_EARLY:
                begin
                    if (s_on && ts_reg > s_lst && (frc_reg || tte_e >= s_per))
                    begin
                        nxt_next[sid] = nv;
                        lst_next[sid] = ts_reg;
                        rt_next       = nv;
                        lm_next       = LM_RESORT;
                        we            = 1'b1;
                        waddr         = '0;
                        wdata         = {sid, tte_e};
                        nf_next       = NF_W'(1);
                    end
                end
                ACT_QUERY:
                begin
                    qry_next     = 1'b1;
                    since_next   = (ts_reg >= s_lst) ? tte_e : '0;
                    until_next_v = (ts_reg >= s_nxt) ? '0 : sat31(s_nxt - ts_reg);
                end
                ACT_INIT:
                begin
                    if (s_on)
                    begin
                        on_next[sid] = 1'b0;
                        lm_next      = LM_REMOVE;
                    end
                    per_next[sid] = pin_reg;
                    int_next[sid] = tk_reg;
                    lst_next[sid] = ts_reg;
                    nxt_next[sid] = tsd;
                end
                default:
                begin
                end
            endcase
        end

        // advance bookkeeping
        if (cmd.run)
            run_next = nt_reg;
        if (cmd.gset)
            glob_next = nt_reg;

        // fire the queue head
        if (cmd.fire)
        begin
            glob_next      = h;
            nxt_next[asel] = h + TIME_W'(s_int);
            lst_next[asel] = h;
            rt_next        = h + TIME_W'(s_int);
            cur_next       = asel;
            lm_next        = LM_RESORT;
            we             = 1'b1;
            waddr          = FIRE_AW'(nf_reg);
            wdata          = {asel, tte_f};
            nf_next        = nf_reg + NF_W'(1);
        end

        // take the slot out of the queue and find its new place
        if (cmd.rem)
        begin
            if (lm_reg == LM_ADD)
                ins_next = IDX_W'(c_add);
            else if (fwd)
                ins_next = IDX_W'(c_le);
            else if (bwd)
                ins_next = IDX_W'(c_lt);
            else
                ins_next = p;
            if (lm_reg != LM_ADD && pf)
            begin
                for (int i = 0; i < NUM_EVENTS - 1; i++)
                begin
                    if (IDX_W'(i) >= p)
                    begin
                        ord_next[i] = ord_reg[i+1];
                        pt_next[i]  = pt_reg[i+1];
                    end
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end

        // put the slot in at its place
        if (cmd.ins)
        begin
            for (int i = 1; i < NUM_EVENTS; i++)
            begin
                if (IDX_W'(i) > ins_reg && CNT_W'(i) <= cnt_reg)
                begin
                    ord_next[i] = ord_reg[i-1];
                    pt_next[i]  = pt_reg[i-1];
                end
            end
            ord_next[ins_reg] = cur_reg;
            pt_next[ins_reg]  = rt_reg;
            cnt_next          = cnt_reg + CNT_W'(1);
        end

        // summary of the queue after the request
        if (cmd.fin)
        begin
            ok_next = '0;
            if (cnt_reg == '0)
            begin
                dc_next  = '1;
                emp_next = 1'b1;
            end
            else
            begin
                emp_next = 1'b0;
                if (h <= glob_reg)
                    dc_next = '0;
                else if ((h - glob_reg) > TIME_W'({DC_W{1'b1}}))
                    dc_next = '1;
                else
                    dc_next = DC_W'(h - glob_reg);
            end
        end

        if (cmd.out)
            ok_next = ok_reg + NF_W'(1);
    end

    // read address runs one ahead of the result index
    assign raddr = cmd.fin ? '0 : FIRE_AW'(ok_reg + NF_W'(1));

    // fire record memory
    always_ff @(posedge clk)
    begin
        if (we)
            fmem[waddr] <= wdata;
        rd_reg <= fmem[raddr];
    end

    // control and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glob_reg <= '0;
            run_reg  <= '0;
            on_reg   <= '0;
            cnt_reg  <= '0;
            lm_reg   <= LM_NONE;
            nf_reg   <= '0;
            ok_reg   <= '0;
            qry_reg  <= 1'b0;
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                nxt_reg[i] <= '0;
                lst_reg[i] <= '0;
                int_reg[i] <= '0;
                per_reg[i] <= '0;
                ord_reg[i] <= '0;
                pt_reg[i]  <= '0;
            end
        end
        else
        begin
            glob_reg <= glob_next;
            run_reg  <= run_next;
            on_reg   <= on_next;
            cnt_reg  <= cnt_next;
            lm_reg   <= lm_next;
            nf_reg   <= nf_next;
            ok_reg   <= ok_next;
            qry_reg  <= qry_next;
            nxt_reg  <= nxt_next;
            lst_reg  <= lst_next;
            int_reg  <= int_next;
            per_reg  <= per_next;
            ord_reg  <= ord_next;
            pt_reg   <= pt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        id_reg    <= id_next;
        tk_reg    <= tk_next;
        pin_reg   <= pin_next;
        frc_reg   <= frc_next;
        ts_reg    <= ts_next;
        nt_reg    <= nt_next;
        rt_reg    <= rt_next;
        cur_reg   <= cur_next;
        ins_reg   <= ins_next;
        since_reg <= since_next;
        until_reg <= until_next_v;
        dc_reg    <= dc_next;
        emp_reg   <= emp_next;
    end

    // status to the controller
    assign stat.is_adv    = (act_reg == ACT_ADVANCE);
    assign stat.head_due  = (cnt_reg != '0) && (h <= nt_reg);
    assign stat.fire_full = (nf_reg == NF_W'(MAX_FIRES));
    assign stat.lmode     = lm_reg;
    assign stat.out_last  = (nf_reg == '0) || (ok_reg == nf_m1);

    // result fields
    always_comb
    begin
        if (nf_reg != '0)
        begin
            kind     = KIND_FIRED;
            fired_id = ID_W'(rd_reg[IDX_W+TICK_W-1:TICK_W]);
            run_gap  = rd_reg[TICK_W-1:0];
        end
        else
        begin
            kind     = qry_reg ? KIND_ANSWER : KIND_ACK;
            fired_id = id_reg;
            run_gap  = '0;
        end
        overdue     = '0;
        since_last  = (nf_reg == '0 && qry_reg) ? since_reg : '0;
        until_next  = (nf_reg == '0 && qry_reg) ? until_reg : '0;
        downcount   = dc_reg;
        queue_empty = emp_reg;
        last        = stat.out_last;
    end

endmodule

### sv/tes_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_ctrl
// Sequencer: request capture, slot command, queue moves, fire loop, results.
// ----------------------------------------------------------------------------
module tes_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tes_pkg::stat_t stat,
    output tes_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           strobe
);
    import tes_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_LIST = 4'd2;
    localparam logic [3:0] S_REM  = 4'd3;
    localparam logic [3:0] S_INS  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0] state_reg, state_next;

    // state transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (!stat.is_adv)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_LIST;
                end
                else if (stat.head_due)
                begin
                    cmd.run    = 1'b1;
                    state_next = S_CHK;
                end
                else
                    state_next = S_FIN;
            end
            S_LIST:
            begin
                if (stat.lmode == LM_NONE)
                    state_next = S_FIN;
                else
                    state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem = 1'b1;
                if (stat.lmode == LM_REMOVE)
                    state_next = S_FIN;
                else
                    state_next = S_INS;
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = stat.is_adv ? S_CHK : S_FIN;
            end
            S_CHK:
            begin
                if (stat.head_due && !stat.fire_full)
                begin
                    cmd.fire   = 1'b1;
                    state_next = S_LIST;
                end
                else if (stat.head_due)
                    state_next = S_FIN;
                else
                begin
                    cmd.gset   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out = 1'b1;
                if (stat.out_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = (state_reg == S_OUT);

endmodule

### sv/timed_event_scheduler.sv
`timescale 1ns / 1ps
// A slot command runs capture, the command, queue moves if needed and finish,
// then gives a single result. An advance with nothing due goes to finish;
// each fire runs fire, mode check, queue remove, queue insert, before results.
// Results then come one per cycle with strobe high; the receiver cannot stall.
// A new request is taken the cycle after the last result; one in work at a time.
// Reset clears all slots, the queue and both time counters; no clearing pass.
// ----------------------------------------------------------------------------
// timed_event_scheduler
// Time-ordered event slot scheduler with fire-on-advance.
// ----------------------------------------------------------------------------
module timed_event_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  action,
    input  logic [3:0]  event_id,
    input  logic [30:0] ticks,
    input  logic [30:0] period_ticks,
    input  logic        force_req,
    input  logic [30:0] backlog,
    output logic        strobe,
    output logic [1:0]  kind,
    output logic [3:0]  fired_id,
    output logic [30:0] run_gap,
    output logic [30:0] overdue,
    output logic [30:0] since_last,
    output logic [30:0] until_next,
    output logic [31:0] downcount,
    output logic        queue_empty,
    output logic        last
);
    import tes_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    tes_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    // slot tables and queue
    tes_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .event_id     (event_id),
        .ticks        (ticks),
        .period_ticks (period_ticks),
        .force_req    (force_req),
        .backlog      (backlog),
        .kind         (kind),
        .fired_id     (fired_id),
        .run_gap      (run_gap),
        .overdue      (overdue),
        .since_last   (since_last),
        .until_next   (until_next),
        .downcount    (downcount),
        .queue_empty  (queue_empty),
        .last         (last)
    );

endmodule

### sv/tes_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_checker
// Port-level checks of the scheduler's request and result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tes_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [1:0]  kind,
    input logic [31:0] downcount,
    input logic        queue_empty,
    input logic        last
);
    import tes_pkg::*;

    // results only while a request is in work
    `ASSERT_IMP(a_strobe_busy, clk, rst_n, strobe, busy)
    // an accepted request keeps the block busy
    `ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // the final result ends the request
    `ASSERT_NXT(a_last_idle, clk, rst_n, strobe && last, !busy)
    // a query answer is always alone
    `ASSERT_IMP(a_answer_last, clk, rst_n, strobe && kind == KIND_ANSWER, last)
    // empty queue reports the saturated downcount
    `ASSERT_IMP(a_empty_dc, clk, rst_n, strobe && queue_empty, downcount == '1)

endmodule

bind timed_event_scheduler tes_checker u_tes_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .kind        (kind),
    .downcount   (downcount),
    .queue_empty (queue_empty),
    .last        (last)
);
